>>> hw/rtl/lrch_pkg.sv
// Shared constants, types and tables for the ring clock-hand renderer.
package lrch_pkg;

    localparam int RING_LEDS      = 24;
    localparam int LED_W          = 5;
    localparam int STATUS_LED_POS = 12;
    localparam int TAIL_LEN       = 6;

    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_WORK  = 2'd1;
    localparam logic [1:0] ST_CAL   = 2'd2;
    localparam logic [1:0] ST_FAULT = 2'd3;

    // Per-frame parameters computed once per accepted time sample.
    typedef struct packed {
        logic [LED_W-1:0] m_cur;
        logic [LED_W-1:0] m_nxt;
        logic [7:0]       m_cl;
        logic [7:0]       m_nl;
        logic             comet;
        logic [LED_W-1:0] h_cur;
        logic [LED_W-1:0] head;
        logic [7:0]       frac;
        logic [1:0]       st;
        logic [7:0]       b;
    } t_frame;

    function automatic logic [7:0] sq_lut(input logic [4:0] k);
        logic [7:0] v;
        unique case (k)
            5'd0: v = 8'd0;     5'd1: v = 8'd2;     5'd2: v = 8'd10;
            5'd3: v = 8'd21;    5'd4: v = 8'd37;    5'd5: v = 8'd57;
            5'd6: v = 8'd79;    5'd7: v = 8'd103;   5'd8: v = 8'd128;
            5'd9: v = 8'd152;   5'd10: v = 8'd176;  5'd11: v = 8'd198;
            5'd12: v = 8'd218;  5'd13: v = 8'd234;  5'd14: v = 8'd245;
            5'd15: v = 8'd253;  default: v = 8'd255;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] tail_lut(input logic [2:0] t);
        logic [7:0] v;
        unique case (t)
            3'd0: v = 8'd255;   3'd1: v = 8'd170;   3'd2: v = 8'd115;
            3'd3: v = 8'd85;    3'd4: v = 8'd75;    3'd5: v = 8'd65;
            default: v = 8'd60;
        endcase
        return v;
    endfunction

    // x / 255 for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] q;
        q = ({1'b0, x} + 17'd1 + {9'd0, x[15:8]}) >> 8;
        return q[7:0];
    endfunction

endpackage

>>> hw/rtl/led_ring_clock_hands_render_unit.sv
// Top level of the ring clock-hand renderer.
// A start transfer passes the frame pipeline, LED counter and both shader stages before
// the first pixel strobe; then one pixel per cycle, 24 per frame, from the single shader.
// busy stays high after each start until the gap counter runs down, so the next frame
// reaches the LED counter in the cycle the previous frame's last LED enters the shader.
// Reset is synchronous and clears all valid bits, the LED counter and busy.
module led_ring_clock_hands_render_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  i_hour_of_day,
    input  logic [5:0]  i_minute_of_hour,
    input  logic [5:0]  i_second_of_minute,
    input  logic [9:0]  i_milli_of_second,
    input  logic [1:0]  i_status_code,
    input  logic [31:0] i_status_time_ms,
    output logic        o_strobe,
    output logic [4:0]  o_led_index,
    output logic [7:0]  o_red_level,
    output logic [7:0]  o_green_level,
    output logic [7:0]  o_blue_level,
    output logic        o_last_pixel
);
    import lrch_pkg::*;

    logic   f_valid;
    t_frame f_frame;
    t_frame r_frame;
    logic   r_run;
    logic [LED_W-1:0] r_led;
    logic [LED_W-1:0] r_gap;
    logic   accept;

    // space transfers one frame sweep apart so a finished frame never waits
    assign busy   = (r_gap != '0);
    assign accept = start && !busy;

    lrch_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_hour  (i_hour_of_day),
        .i_min   (i_minute_of_hour),
        .i_sec   (i_second_of_minute),
        .i_ms    (i_milli_of_second),
        .i_st    (i_status_code),
        .i_stt   (i_status_time_ms),
        .o_valid (f_valid),
        .o_frame (f_frame)
    );

    // sweep the LED counter over each frame that leaves the parameter pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
            r_run <= 1'b0;
            r_led <= '0;
        end else begin
            if (accept) begin
                r_gap <= LED_W'(RING_LEDS - 1);
            end else if (r_gap != '0) begin
                r_gap <= r_gap - 1'b1;
            end
            if (f_valid) begin
                r_run <= 1'b1;
                r_led <= '0;
            end else if (r_run && r_led != LED_W'(RING_LEDS - 1)) begin
                r_led <= r_led + 1'b1;
            end else begin
                r_run <= 1'b0;
            end
        end
        if (f_valid) r_frame <= f_frame;
    end

    lrch_pixel u_pixel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_run),
        .i_frame (r_frame),
        .i_led   (r_led),
        .i_last  (r_led == LED_W'(RING_LEDS - 1)),
        .o_valid (o_strobe),
        .o_led   (o_led_index),
        .o_r     (o_red_level),
        .o_g     (o_green_level),
        .o_b     (o_blue_level),
        .o_last  (o_last_pixel)
    );

endmodule

>>> hw/rtl/lrch_frame.sv
// Pipelined per-frame parameter computation: hand positions, fade, comet, breathing.
module lrch_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [4:0]        i_hour,
    input  logic [5:0]        i_min,
    input  logic [5:0]        i_sec,
    input  logic [9:0]        i_ms,
    input  logic [1:0]        i_st,
    input  logic [31:0]       i_stt,
    output logic              o_valid,
    output lrch_pkg::t_frame  o_frame
);
    import lrch_pkg::*;

    // stage 1: elapsed times, status phase start
    logic        r_v1, n_v1;
    logic [21:0] r_mel;
    logic [25:0] r_hel;
    logic [1:0]  r_st1;
    logic [31:0] r_stt1;
    logic [9:0]  ms_c;
    logic [3:0]  hmod;

    always_comb begin
        n_v1 = i_valid;
        ms_c = (i_ms > 10'd999) ? 10'd999 : i_ms;
        hmod = (i_hour >= 5'd24) ? 4'(i_hour - 5'd24) :
               (i_hour >= 5'd12) ? 4'(i_hour - 5'd12) : i_hour[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
        end
        r_mel  <= 22'(i_min) * 22'd60000 + 22'(i_sec) * 22'd1000 + 22'(ms_c);
        r_hel  <= 26'(hmod) * 26'd3600000 + 26'(i_min) * 26'd60000
                  + 26'(i_sec) * 26'd1000 + 26'(ms_c);
        r_st1  <= i_st;
        r_stt1 <= i_stt;
    end

    // stage 2: quotient/remainder by step sizes, status phase mod 3400
    logic        r_v2;
    logic [4:0]  r_mq;
    logic [17:0] r_mph;
    logic [3:0]  r_hq;
    logic [21:0] r_hph;
    logic [1:0]  r_st2;
    logic [11:0] ph;
    logic [4:0]  mq;
    logic [3:0]  hq;
    logic [31:0] squot;

    always_comb begin
        mq = 5'd0;
        for (int k = 1; k <= 25; k++)
            if (r_mel >= 22'(k * 150000)) mq = 5'(k);
        hq = 4'd0;
        for (int k = 1; k <= 12; k++)
            if (r_hel >= 26'(k * 3600000)) hq = 4'(k);
        // floor(t/3400) via reciprocal; may come out one short, fixed below
        squot = 32'((64'(r_stt1) * 64'd1293543091) >> 42);
    end

    logic [31:0] r_sq;
    logic [31:0] r_srem;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_mq   <= mq;
        r_mph  <= 18'(r_mel - 22'(32'(mq) * 32'd150000));
        r_hq   <= hq;
        r_hph  <= 22'(r_hel - 26'(32'(hq) * 32'd3600000));
        r_st2  <= r_st1;
        r_sq   <= squot;
        r_srem <= r_stt1;
    end

    logic [43:0] rem_full;
    always_comb begin
        rem_full = 44'(r_srem) - 44'(r_sq) * 44'd3400;
        ph = 12'(rem_full >= 44'd3400 ? rem_full - 44'd3400 : rem_full);
    end

    // stage 3: fade offset, comet travel, status wave products
    logic        r_v3;
    logic [4:0]  r_mq3;
    logic        r_fade;
    logic [13:0] r_sc;
    logic [1:0]  r_st3;
    logic [3:0]  r_hq3;
    logic        r_comet;
    logic [22:0] r_trav;
    logic [19:0] r_bnum;
    logic        r_brise, r_bzero;
    logic [9:0]  p;

    always_comb p = 10'(r_mph - 18'd149000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_mq3   <= r_mq;
        r_fade  <= r_mph >= 18'd149000;
        r_sc    <= 14'(p) * 14'd16;
        r_hq3   <= r_hq;
        r_comet <= r_hph < 22'd1200;
        // 25 steps of 255 over 1200 ms is exactly 85/16 per ms
        r_trav  <= 23'((32'(r_hph[10:0]) * 32'd85) >> 4);
        r_st3   <= r_st2;
        r_bzero <= ph >= 12'd1300;
        r_brise <= ph <= 12'd500;
        r_bnum  <= (ph <= 12'd500) ? 20'(ph) * 20'd255 : 20'(12'd1300 - ph) * 20'd255;
    end

    // stage 4: divisions by constants
    logic        r_v4;
    logic [4:0]  r_mq4;
    logic        r_fade4;
    logic [3:0]  r_k;
    logic [9:0]  r_r;
    logic [1:0]  r_st4;
    logic [3:0]  r_hq4;
    logic        r_comet4;
    logic [4:0]  r_steps;
    logic [7:0]  r_frac;
    logic [7:0]  r_b;
    logic [13:0] kq;
    logic [13:0] tq;

    always_comb begin
        kq = 14'((32'(r_sc) * 32'd16778) >> 24);
        if (r_sc - 14'(32'(kq) * 32'd1000) >= 14'd1000) kq = kq + 14'd1;
        tq = 14'((40'(r_trav) * 40'd8421505) >> 31);
        if (23'(r_trav - 23'(32'(tq) * 32'd255)) >= 23'd255) tq = tq + 14'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_mq4    <= r_mq3;
        r_fade4  <= r_fade;
        r_k      <= kq[3:0];
        r_r      <= 10'(r_sc - 14'(32'(kq) * 32'd1000));
        r_st4    <= r_st3;
        r_hq4    <= r_hq3;
        r_comet4 <= r_comet;
        r_steps  <= 5'(tq);
        r_frac   <= 8'(r_trav - 23'(32'(tq) * 32'd255));
        r_b      <= r_bzero ? 8'd0 :
                    r_brise ? 8'((32'(r_bnum) * 32'd33555) >> 24) :
                              8'(r_bnum >> 3 > 0 ? (32'(r_bnum) * 32'd20972) >> 24 : 0);
    end

    // stage 5: interpolation product, hour hand and comet head positions
    logic        r_v5;
    logic [4:0]  r_mq5;
    logic        r_fade5;
    logic [7:0]  r_lo;
    logic [17:0] r_ip;
    t_frame      r_f5;
    logic [7:0]  lo, hi;
    logic [4:0]  prev, hd, hc;
    logic [5:0]  hsum;

    always_comb begin
        lo = sq_lut({1'b0, r_k});
        hi = sq_lut(5'(r_k) + 5'd1);
        // hour 12 of the elapsed count wraps back to LED 0
        hc = (r_hq4 == 4'd12) ? 5'd0 : 5'(r_hq4) * 5'd2;
        prev = (hc >= 5'd2) ? hc - 5'd2 : 5'(hc + 5'd22);
        hsum = 6'(prev) + 6'(r_steps);
        hd = (hsum >= 6'd24) ? 5'(hsum - 6'd24) : hsum[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        r_mq5   <= r_mq4;
        r_fade5 <= r_fade4;
        r_lo    <= lo;
        r_ip    <= 18'(hi - lo) * 18'(r_r);
        r_f5.comet <= r_comet4;
        r_f5.h_cur <= hc;
        r_f5.head  <= hd;
        r_f5.frac  <= r_frac;
        r_f5.st    <= r_st4;
        r_f5.b     <= r_b;
        r_f5.m_cur <= '0;
        r_f5.m_nxt <= '0;
        r_f5.m_cl  <= '0;
        r_f5.m_nl  <= '0;
    end

    // stage 6: final minute-hand levels
    logic [7:0] nl;
    logic [4:0] mc;
    t_frame     n_frame;
    always_comb begin
        nl = 8'(r_lo + 8'((32'(r_ip) * 32'd16778) >> 24));
        if (32'(r_ip) - ((32'(r_ip) * 32'd16778) >> 24) * 32'd1000 >= 32'd1000) nl = nl + 8'd1;
        mc = (r_mq5 >= 5'd24) ? r_mq5 - 5'd24 : r_mq5;
        n_frame       = r_f5;
        n_frame.m_cur = mc;
        n_frame.m_nxt = (mc == 5'd23) ? 5'd0 : mc + 5'd1;
        n_frame.m_nl  = r_fade5 ? nl : 8'd0;
        n_frame.m_cl  = r_fade5 ? 8'(8'd255 - nl) : 8'd255;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v5;
        end
        o_frame <= n_frame;
    end

endmodule

>>> hw/rtl/lrch_pixel.sv
// Per-LED pixel shading: comet, hands, mixing and status overlay.
module lrch_pixel (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lrch_pkg::t_frame  i_frame,
    input  logic [4:0]        i_led,
    input  logic              i_last,
    output logic              o_valid,
    output logic [4:0]        o_led,
    output logic [7:0]        o_r,
    output logic [7:0]        o_g,
    output logic [7:0]        o_b,
    output logic              o_last
);
    import lrch_pkg::*;

    // stage A: per-LED comet products and hand levels
    logic        r_va;
    logic [4:0]  r_led;
    logic        r_last;
    t_frame      r_f;
    logic [7:0]  r_h;
    logic [7:0]  r_m;
    logic [7:0]  h_lvl;
    logic [7:0]  cur, sh;
    logic [4:0]  d, dn;
    logic [2:0]  t;

    always_comb begin
        h_lvl = 8'd0;
        cur   = 8'd0;
        sh    = 8'd0;
        t     = 3'd0;
        d  = (i_frame.head >= i_led) ? i_frame.head - i_led : 5'(i_frame.head + 5'd24 - i_led);
        dn = (d == 5'd23) ? 5'd0 : d + 5'd1;
        if (i_frame.comet) begin
            // own-tail level at distance d, shed from neighbor at distance d+1
            if (d <= 5'd6) begin
                t = d[2:0];
                cur = (d == 5'd0) ? 8'd255
                      : div255(16'(tail_lut(t)) * 16'(8'd255 - i_frame.frac));
                if (cur > h_lvl) h_lvl = cur;
            end
            if (dn <= 5'd6 && (dn == 5'd0 || d != 5'd0)) begin
                t = dn[2:0];
                sh = div255(16'(tail_lut(t)) * 16'(i_frame.frac));
                if (sh > h_lvl) h_lvl = sh;
            end
        end else if (i_led == i_frame.h_cur) begin
            h_lvl = 8'd255;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= i_valid;
        end
        r_led  <= i_led;
        r_last <= i_last;
        r_f    <= i_frame;
        r_h    <= h_lvl;
        r_m    <= (i_led == i_frame.m_cur) ? i_frame.m_cl :
                  (i_led == i_frame.m_nxt) ? i_frame.m_nl : 8'd0;
    end

    // stage B: mix and overlay
    logic [7:0] pr, pg, pb, l;
    logic       white;
    always_comb begin
        l = (r_h > r_m) ? r_h : r_m;
        if (r_h != 8'd0 && r_m != 8'd0) begin
            pr = 8'd0; pg = l; pb = 8'(({1'b0, l} + 9'd1) >> 1);
        end else if (r_h != 8'd0) begin
            pr = r_h; pg = r_h; pb = r_h;
        end else begin
            pr = 8'd0; pg = r_m; pb = 8'd0;
        end
        white = pr != 8'd0 && pr == pg && pg == pb;
        if (r_led == 5'(STATUS_LED_POS) && r_f.st != ST_NONE) begin
            if (r_f.st == ST_FAULT) begin
                pr = r_f.b; pg = 8'd0; pb = 8'd0;
            end else if (!white) begin
                pr = 8'd0; pg = r_f.b; pb = (r_f.st == ST_CAL) ? r_f.b : 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_va;
        end
        o_led  <= r_led;
        o_last <= r_last;
        o_r    <= pr;
        o_g    <= pg;
        o_b    <= pb;
    end

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the ring clock-hand renderer: predicts every frame and checks each pixel.
`timescale 1ns / 1ps

module tb_top;
    import lrch_pkg::*;

    typedef struct {
        logic [4:0] led;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_pixel;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [4:0]  i_hour_of_day;
    logic [5:0]  i_minute_of_hour;
    logic [5:0]  i_second_of_minute;
    logic [9:0]  i_milli_of_second;
    logic [1:0]  i_status_code;
    logic [31:0] i_status_time_ms;
    logic        o_strobe;
    logic [4:0]  o_led_index;
    logic [7:0]  o_red_level;
    logic [7:0]  o_green_level;
    logic [7:0]  o_blue_level;
    logic        o_last_pixel;

    t_pixel pending_pixels[$];
    int     error_count;
    int     frame_count;
    int     pixel_count;
    int     burst_left;

    led_ring_clock_hands_render_unit i_dut (.*);

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    initial begin
        #50_000_000;
        $display("FAIL led_ring_clock_hands_render_unit");
        $finish;
    end

    localparam int SQ_LEVELS[17] = '{0, 2, 10, 21, 37, 57, 79, 103, 128,
                                     152, 176, 198, 218, 234, 245, 253, 255};
    localparam int TAIL_LEVELS[6] = '{170, 115, 85, 75, 65, 60};

    function automatic int crossfade_level(int p);
        int scaled, k, r;
        if (p >= 1000) return 255;
        scaled = p * 16;
        k = (scaled / 1000) & 15;
        r = scaled % 1000;
        return SQ_LEVELS[k] + ((SQ_LEVELS[k + 1] - SQ_LEVELS[k]) * r) / 1000;
    endfunction

    function automatic int breathing_level(logic [31:0] t);
        int ph;
        ph = int'(t % 32'd3400);
        if (ph >= 1300) return 0;
        if (ph <= 500) return ph * 255 / 500;
        return (1300 - ph) * 255 / 800;
    endfunction

    // Build the expected 24-pixel frame for one time sample.
    task automatic predict_frame(input logic [4:0] hr, input logic [5:0] mn,
                                 input logic [5:0] sc, input logic [9:0] ms_in,
                                 input logic [1:0] st, input logic [31:0] stt);
        int hour_lv[24], min_lv[24], rgb[24][3];
        int ms, m_el, h_el, m_ph, m_cur, m_nl, h_ph, h_cur;
        int prev, trav, head, frac, idx, nxt, base, cur, sh, h, m, l, b;
        t_pixel px;
        ms = (ms_in > 999) ? 999 : int'(ms_in);
        m_el = (int'(mn) * 60 + int'(sc)) * 1000 + ms;
        h_el = (((int'(hr) % 12) * 60 + int'(mn)) * 60 + int'(sc)) * 1000 + ms;
        for (int i = 0; i < 24; i++) begin
            hour_lv[i] = 0;
            min_lv[i] = 0;
        end
        m_ph = m_el % 150000;
        m_cur = (m_el / 150000) % 24;
        m_nl = 0;
        if (m_ph >= 149000) m_nl = crossfade_level(m_ph - 149000);
        h_ph = h_el % 3600000;
        h_cur = ((h_el / 3600000) * 2) % 24;
        if (h_ph < 1200) begin
            prev = (h_cur + 22) % 24;
            trav = h_ph * 25 * 255 / 1200;
            head = (prev + trav / 255) % 24;
            frac = trav % 255;
            for (int t = 0; t <= 6; t++) begin
                idx = (head + 24 - t) % 24;
                nxt = (idx + 1) % 24;
                base = (t == 0) ? 255 : TAIL_LEVELS[t - 1];
                cur = (t == 0) ? base : base * (255 - frac) / 255;
                sh = base * frac / 255;
                if (cur > hour_lv[idx]) hour_lv[idx] = cur;
                if ((t == 0 || nxt != head) && sh > hour_lv[nxt]) hour_lv[nxt] = sh;
            end
        end else begin
            hour_lv[h_cur] = 255;
        end
        min_lv[m_cur] = 255 - m_nl;
        min_lv[(m_cur + 1) % 24] = m_nl;
        for (int i = 0; i < 24; i++) begin
            h = hour_lv[i];
            m = min_lv[i];
            if (h != 0 && m != 0) begin
                l = (h > m) ? h : m;
                rgb[i] = '{0, l, (l + 1) / 2};
            end else if (h != 0) begin
                rgb[i] = '{h, h, h};
            end else begin
                rgb[i] = '{0, m, 0};
            end
        end
        if (st != ST_NONE) begin
            b = breathing_level(stt);
            if (st == ST_FAULT) begin
                rgb[STATUS_LED_POS] = '{b, 0, 0};
            end else if (!(rgb[STATUS_LED_POS][0] != 0
                           && rgb[STATUS_LED_POS][0] == rgb[STATUS_LED_POS][1]
                           && rgb[STATUS_LED_POS][1] == rgb[STATUS_LED_POS][2])) begin
                rgb[STATUS_LED_POS] = '{0, b, (st == ST_CAL) ? b : 0};
            end
        end
        for (int i = 0; i < 24; i++) begin
            px.led = 5'(i);
            px.red = 8'(rgb[i][0]);
            px.green = 8'(rgb[i][1]);
            px.blue = 8'(rgb[i][2]);
            px.last = (i == 23);
            pending_pixels.push_back(px);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Check each pixel transfer against the oldest expected pixel.
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_strobe) begin
            pixel_count++;
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel led %0d", o_led_index));
            end else begin
                want = pending_pixels.pop_front();
                if (o_led_index !== want.led || o_red_level !== want.red
                    || o_green_level !== want.green || o_blue_level !== want.blue
                    || o_last_pixel !== want.last)
                    report_mismatch($sformatf(
                        "led %0d rgb %0d/%0d/%0d last %0d, want led %0d rgb %0d/%0d/%0d last %0d",
                        o_led_index, o_red_level, o_green_level, o_blue_level, o_last_pixel,
                        want.led, want.red, want.green, want.blue, want.last));
            end
        end
    end

    // Send one time sample; inserts a random gap between bursts.
    task automatic send_sample(input logic [4:0] hr, input logic [5:0] mn,
                               input logic [5:0] sc, input logic [9:0] ms,
                               input logic [1:0] st, input logic [31:0] stt);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 40);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_hour_of_day <= hr;
        i_minute_of_hour <= mn;
        i_second_of_minute <= sc;
        i_milli_of_second <= ms;
        i_status_code <= st;
        i_status_time_ms <= stt;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_frame(hr, mn, sc, ms, st, stt);
        frame_count++;
    endtask

    task automatic test_field_extremes();
        send_sample(5'd0, 6'd0, 6'd0, 10'd0, ST_NONE, 32'd0);
        send_sample(5'd31, 6'd63, 6'd63, 10'd1023, ST_FAULT, 32'hFFFF_FFFF);
        send_sample(5'd23, 6'd59, 6'd59, 10'd999, ST_WORK, 32'd500);
        send_sample(5'd12, 6'd0, 6'd0, 10'd1000, ST_CAL, 32'd250);
    endtask

    task automatic test_status_overlay();
        // hour 6 puts the white hour hand on the status LED
        send_sample(5'd6, 6'd20, 6'd0, 10'd0, ST_WORK, 32'd500);
        send_sample(5'd6, 6'd20, 6'd0, 10'd0, ST_CAL, 32'd900);
        send_sample(5'd6, 6'd20, 6'd0, 10'd0, ST_FAULT, 32'd3000);
        send_sample(5'd6, 6'd20, 6'd0, 10'd0, ST_NONE, 32'd100);
        send_sample(5'd3, 6'd30, 6'd0, 10'd0, ST_WORK, 32'd1299);
        send_sample(5'd3, 6'd30, 6'd0, 10'd0, ST_CAL, 32'd3399);
    endtask

    task automatic test_minute_crossfade();
        send_sample(5'd1, 6'd2, 6'd29, 10'd0, ST_NONE, 32'd0);
        send_sample(5'd1, 6'd2, 6'd29, 10'd500, ST_NONE, 32'd0);
        send_sample(5'd1, 6'd2, 6'd29, 10'd937, ST_NONE, 32'd0);
        send_sample(5'd1, 6'd57, 6'd29, 10'd999, ST_NONE, 32'd0);
        send_sample(5'd2, 6'd2, 6'd30, 10'd0, ST_NONE, 32'd0);
    endtask

    task automatic test_hour_comet();
        send_sample(5'd0, 6'd0, 6'd0, 10'd1, ST_NONE, 32'd0);
        send_sample(5'd5, 6'd0, 6'd0, 10'd300, ST_NONE, 32'd0);
        send_sample(5'd5, 6'd0, 6'd0, 10'd777, ST_WORK, 32'd200);
        send_sample(5'd9, 6'd0, 6'd1, 10'd150, ST_NONE, 32'd0);
        send_sample(5'd9, 6'd0, 6'd1, 10'd199, ST_NONE, 32'd0);
        send_sample(5'd9, 6'd0, 6'd1, 10'd200, ST_NONE, 32'd0);
    endtask

    task automatic test_random_samples();
        logic [5:0] mn, sc;
        logic [9:0] ms;
        for (int n = 0; n < 210; n++) begin
            mn = 6'($urandom_range(0, 59));
            sc = 6'($urandom_range(0, 59));
            ms = 10'($urandom_range(0, 1023));
            case ($urandom_range(0, 5))
                0: begin
                    mn = 6'd0;
                    sc = 6'($urandom_range(0, 1));
                end
                1: begin
                    // land in the last second of a minute-hand step
                    mn = 6'($urandom_range(0, 23) * 5 / 2 + 2);
                    sc = (mn % 5 == 2) ? 6'd29 : 6'd59;
                end
                2: begin
                    mn = 6'($urandom);
                    sc = 6'($urandom);
                end
                default: ;
            endcase
            send_sample(5'($urandom), mn, sc, ms, 2'($urandom),
                        ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 6800));
        end
    endtask

    initial begin
        int guard;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_hour_of_day = '0;
        i_minute_of_hour = '0;
        i_second_of_minute = '0;
        i_milli_of_second = '0;
        i_status_code = ST_NONE;
        i_status_time_ms = '0;
        error_count = 0;
        frame_count = 0;
        pixel_count = 0;
        burst_left = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_status_overlay();
        test_minute_crossfade();
        test_hour_comet();
        test_random_samples();
        start <= 1'b0;

        guard = 0;
        while (pending_pixels.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
        if (pending_pixels.size() != 0)
            report_mismatch($sformatf("%0d pixels never arrived", pending_pixels.size()));
        $display("covered %0d frames, %0d pixels: hands, crossfade, comet, status overlay",
                 frame_count, pixel_count);
        if (error_count == 0) begin
            $display("PASS led_ring_clock_hands_render_unit");
        end else begin
            $display("FAIL led_ring_clock_hands_render_unit");
        end
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/lrch_pkg.sv
hw/rtl/lrch_frame.sv
hw/rtl/lrch_pixel.sv
hw/rtl/led_ring_clock_hands_render_unit.sv
verif/tb_top.sv
